// File: src/cpit_pkg.sv
// ----------------------------------------------------------------------------
// cpit_pkg : shared constants and types for the pattern intern table
// Sizes, command codes and the request bundles that go to the two memories.
// ----------------------------------------------------------------------------
package cpit_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int MAP_SIDE      = 128;
    localparam int PRESETS       = 16;

    localparam logic [7:0] GO_BIT = 8'd1;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int CELLS  = MAP_SIDE * MAP_SIDE;
    localparam int CELL_W = $clog2(CELLS);
    localparam int PAT_W  = 32;
    localparam int PRE_W  = $clog2(PRESETS);

    localparam logic [2:0] CMD_STORE     = 3'd0;
    localparam logic [2:0] CMD_CLR_GO    = 3'd1;
    localparam logic [2:0] CMD_SET_GO    = 3'd2;
    localparam logic [2:0] CMD_BLK_BITS  = 3'd3;
    localparam logic [2:0] CMD_BLK_WHOLE = 3'd4;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [PAT_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_dict_req;

    typedef struct packed {
        logic              we;
        logic [CELL_W-1:0] waddr;
        logic [IDX_W-1:0]  wdata;
        logic [CELL_W-1:0] raddr;
    } t_grid_req;

endpackage

// File: src/cell_pattern_intern_table_core.sv
// ----------------------------------------------------------------------------
// cell_pattern_intern_table_core : deduplicating pattern dictionary over a grid
//
//  channel | signals                         | beat carries
//  --------+---------------------------------+-------------------------------
//  in      | i_in_valid / o_in_stall         | cmd, cell_x, cell_z, direction,
//          |                                 | pattern_b0..b3
//  out     | o_out_valid / i_out_stall       | entry_index, entry_total,
//          |                                 | table_full, caps_b0..b3
//
// One command at a time. The duration of a store is set by the linear
// dictionary scan (one entry read per cycle); a block command scans once per
// in-map neighbour, so up to four scans. After reset the grid is swept to
// zero with the input stalled. The result sits in an output register, so a
// stalled output does not hold back the next input beat.
// ----------------------------------------------------------------------------
module cell_pattern_intern_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [6:0]  i_cell_x,
    input  logic [6:0]  i_cell_z,
    input  logic [1:0]  i_direction,
    input  logic [7:0]  i_pattern_b0,
    input  logic [7:0]  i_pattern_b1,
    input  logic [7:0]  i_pattern_b2,
    input  logic [7:0]  i_pattern_b3,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_entry_index,
    output logic [10:0] o_entry_total,
    output logic        o_table_full,
    output logic [7:0]  o_caps_b0,
    output logic [7:0]  o_caps_b1,
    output logic [7:0]  o_caps_b2,
    output logic [7:0]  o_caps_b3
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_NB     = 4'd1;
    localparam logic [3:0] ST_G_RD   = 4'd2;
    localparam logic [3:0] ST_D_RD   = 4'd3;
    localparam logic [3:0] ST_EDIT   = 4'd4;
    localparam logic [3:0] ST_SRCH   = 4'd5;
    localparam logic [3:0] ST_NEXT   = 4'd6;
    localparam logic [3:0] ST_F_RD   = 4'd7;
    localparam logic [3:0] ST_F_DICT = 4'd8;
    localparam logic [3:0] ST_F_CAP  = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    localparam int IDX_W  = cpit_pkg::IDX_W;
    localparam int CNT_W  = cpit_pkg::CNT_W;
    localparam int CELL_W = cpit_pkg::CELL_W;
    localparam int PAT_W  = cpit_pkg::PAT_W;

    logic [3:0]        r_state, n_state;
    logic [2:0]        r_cmd;
    logic [7:0]        r_x, r_z;
    logic [1:0]        r_dir;
    logic [1:0]        r_nb;
    logic [CELL_W-1:0] r_tgt;
    logic [PAT_W-1:0]  r_pat;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_ptr;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_vld;
    logic              r_full;
    logic [IDX_W-1:0]  r_idx;
    logic [PAT_W-1:0]  r_caps;

    logic              r_ov;
    logic [IDX_W-1:0]  r_o_idx;
    logic [CNT_W-1:0]  r_o_total;
    logic              r_o_full;
    logic [PAT_W-1:0]  r_o_caps;

    cpit_pkg::t_dict_req dict_req;
    cpit_pkg::t_grid_req grid_req;
    logic [PAT_W-1:0]    dict_rdata;
    logic [IDX_W-1:0]    grid_rdata;
    logic                grid_busy;

    logic              in_acc;
    logic              is_block;
    logic              nb_in;
    logic [7:0]        nb_x, nb_z;
    logic              hit, issue, miss_done;
    logic              out_load;

    cpit_dict u_dict (
        .i_clk   (i_clk),
        .i_req   (dict_req),
        .o_rdata (dict_rdata)
    );

    cpit_grid u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (grid_req),
        .o_rdata (grid_rdata),
        .o_busy  (grid_busy)
    );

    function automatic logic [CELL_W-1:0] cell_addr(input logic [7:0] x, input logic [7:0] z);
        return CELL_W'(int'(z) * cpit_pkg::MAP_SIDE + int'(x));
    endfunction

    function automatic logic [PAT_W-1:0] edit_pat(
        input logic [PAT_W-1:0] pat,
        input logic [1:0]       sel,
        input logic [2:0]       cmd
    );
        logic [PAT_W-1:0] p;
        logic [7:0]       b;
        p = pat;
        b = pat[sel*8 +: 8];
        case (cmd)
            cpit_pkg::CMD_CLR_GO, cpit_pkg::CMD_BLK_BITS: b = b & ~cpit_pkg::GO_BIT;
            cpit_pkg::CMD_SET_GO:                         b = cpit_pkg::GO_BIT;
            default:                                      b = 8'd0;
        endcase
        p[sel*8 +: 8] = b;
        return p;
    endfunction

    assign o_in_stall = (r_state != ST_IDLE) || grid_busy;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_block   = (r_cmd == cpit_pkg::CMD_BLK_BITS) || (r_cmd == cpit_pkg::CMD_BLK_WHOLE);

    // neighbour order: +x, -x, +z, -z
    always_comb begin
        nb_x  = r_x;
        nb_z  = r_z;
        nb_in = 1'b0;
        case (r_nb)
            2'd0: begin
                nb_x  = r_x + 8'd1;
                nb_in = (int'(r_x) + 1 < cpit_pkg::MAP_SIDE);
            end
            2'd1: begin
                nb_x  = r_x - 8'd1;
                nb_in = (r_x != 8'd0);
            end
            2'd2: begin
                nb_z  = r_z + 8'd1;
                nb_in = (int'(r_z) + 1 < cpit_pkg::MAP_SIDE);
            end
            default: begin
                nb_z  = r_z - 8'd1;
                nb_in = (r_z != 8'd0);
            end
        endcase
    end

    // scan: one read issued per cycle, each compared in the cycle after
    assign hit       = (r_state == ST_SRCH) && r_cmp_vld && (dict_rdata == r_pat);
    assign issue     = (r_state == ST_SRCH) && !hit && (r_ptr < r_count);
    assign miss_done = (r_state == ST_SRCH) && !hit && !issue && !r_cmp_vld;

    always_comb begin
        dict_req       = '0;
        grid_req       = '0;
        dict_req.wdata = r_pat;
        dict_req.waddr = r_count[IDX_W-1:0];
        grid_req.waddr = r_tgt;
        case (r_state)
            ST_G_RD:   grid_req.raddr = r_tgt;
            ST_F_RD:   grid_req.raddr = cell_addr(r_x, r_z);
            ST_D_RD:   dict_req.raddr = grid_rdata;
            ST_F_DICT: dict_req.raddr = grid_rdata;
            ST_SRCH:   dict_req.raddr = r_ptr[IDX_W-1:0];
            default:   dict_req.raddr = '0;
        endcase
        if (hit) begin
            grid_req.we    = 1'b1;
            grid_req.wdata = r_cmp_idx;
        end else if (miss_done && (r_count < CNT_W'(cpit_pkg::TABLE_ENTRIES))) begin
            grid_req.we    = 1'b1;
            grid_req.wdata = r_count[IDX_W-1:0];
            dict_req.we    = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!((int'(i_cell_x) < cpit_pkg::MAP_SIDE) &&
                          (int'(i_cell_z) < cpit_pkg::MAP_SIDE))) begin
                        n_state = ST_DONE;
                    end else begin
                        case (i_cmd)
                            cpit_pkg::CMD_STORE:                         n_state = ST_SRCH;
                            cpit_pkg::CMD_CLR_GO, cpit_pkg::CMD_SET_GO:  n_state = ST_G_RD;
                            cpit_pkg::CMD_BLK_BITS,
                            cpit_pkg::CMD_BLK_WHOLE:                     n_state = ST_NB;
                            default:                                     n_state = ST_F_RD;
                        endcase
                    end
                end
            end
            ST_NB:     n_state = nb_in ? ST_G_RD : ST_NEXT;
            ST_G_RD:   n_state = ST_D_RD;
            ST_D_RD:   n_state = ST_EDIT;
            ST_EDIT:   n_state = ST_SRCH;
            ST_SRCH:   n_state = (hit || miss_done) ? ST_NEXT : ST_SRCH;
            ST_NEXT:   n_state = (is_block && (r_nb != 2'd3)) ? ST_NB : ST_F_RD;
            ST_F_RD:   n_state = ST_F_DICT;
            ST_F_DICT: n_state = ST_F_CAP;
            ST_F_CAP:  n_state = ST_DONE;
            ST_DONE:   n_state = (!r_ov || !i_out_stall) ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    assign out_load = (r_state == ST_DONE) && (!r_ov || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= CNT_W'(cpit_pkg::PRESETS);
            r_ov      <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (dict_req.we) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == ST_SRCH) begin
                r_cmp_vld <= issue;
            end else begin
                r_cmp_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cmd  <= i_cmd;
                r_x    <= {1'b0, i_cell_x};
                r_z    <= {1'b0, i_cell_z};
                r_dir  <= i_direction;
                r_nb   <= 2'd0;
                r_tgt  <= cell_addr({1'b0, i_cell_x}, {1'b0, i_cell_z});
                r_pat  <= {i_pattern_b3, i_pattern_b2, i_pattern_b1, i_pattern_b0};
                r_ptr  <= '0;
                r_full <= 1'b0;
                r_idx  <= '0;
                r_caps <= '0;
            end
            ST_NB: begin
                r_tgt <= cell_addr(nb_x, nb_z);
            end
            ST_EDIT: begin
                r_pat <= edit_pat(dict_rdata, is_block ? r_nb : r_dir, r_cmd);
                r_ptr <= '0;
            end
            ST_SRCH: begin
                if (issue) begin
                    r_ptr     <= r_ptr + 1'b1;
                    r_cmp_idx <= r_ptr[IDX_W-1:0];
                end
                if (miss_done && (r_count >= CNT_W'(cpit_pkg::TABLE_ENTRIES))) begin
                    r_full <= 1'b1;
                end
            end
            ST_NEXT: begin
                r_nb <= r_nb + 2'd1;
            end
            ST_F_DICT: begin
                r_idx <= is_block ? '0 : grid_rdata;
            end
            ST_F_CAP: begin
                r_caps <= dict_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_idx   <= r_idx;
            r_o_total <= r_count;
            r_o_full  <= r_full;
            r_o_caps  <= r_caps;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_entry_index = r_o_idx;
    assign o_entry_total = r_o_total;
    assign o_table_full  = r_o_full;
    assign o_caps_b0     = r_o_caps[7:0];
    assign o_caps_b1     = r_o_caps[15:8];
    assign o_caps_b2     = r_o_caps[23:16];
    assign o_caps_b3     = r_o_caps[31:24];

endmodule

// File: src/cpit_dict.sv
// ----------------------------------------------------------------------------
// cpit_dict : pattern dictionary storage
// Synchronous RAM with a registered read; the preset entries are served from constant logic.
// ----------------------------------------------------------------------------
module cpit_dict (
    input  logic                      i_clk,
    input  cpit_pkg::t_dict_req       i_req,
    output logic [cpit_pkg::PAT_W-1:0] o_rdata
);

    logic [cpit_pkg::PAT_W-1:0] r_mem [cpit_pkg::TABLE_ENTRIES];
    logic [cpit_pkg::PAT_W-1:0] r_q;
    logic [cpit_pkg::PAT_W-1:0] r_pre;
    logic                       r_sel_pre;

    // entry i: byte k holds GO_BIT when bit k of i is clear
    function automatic logic [cpit_pkg::PAT_W-1:0] preset_pat(
        input logic [cpit_pkg::PRE_W-1:0] i
    );
        logic [cpit_pkg::PAT_W-1:0] p;
        p = '0;
        for (int k = 0; k < 4; k++) begin
            if (!i[k]) begin
                p[k*8 +: 8] = cpit_pkg::GO_BIT;
            end
        end
        return p;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_q       <= r_mem[i_req.raddr];
        r_pre     <= preset_pat(i_req.raddr[cpit_pkg::PRE_W-1:0]);
        r_sel_pre <= (i_req.raddr < cpit_pkg::IDX_W'(cpit_pkg::PRESETS));
    end

    assign o_rdata = r_sel_pre ? r_pre : r_q;

endmodule

// File: src/cpit_grid.sv
// ----------------------------------------------------------------------------
// cpit_grid : cell index grid
// Synchronous RAM with a zeroing sweep after reset, one cell per cycle.
// ----------------------------------------------------------------------------
module cpit_grid (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cpit_pkg::t_grid_req        i_req,
    output logic [cpit_pkg::IDX_W-1:0] o_rdata,
    output logic                       o_busy
);

    logic [cpit_pkg::IDX_W-1:0]  r_mem [cpit_pkg::CELLS];
    logic [cpit_pkg::IDX_W-1:0]  r_q;
    logic [cpit_pkg::CELL_W-1:0] r_clr_addr;
    logic                        r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == cpit_pkg::CELL_W'(cpit_pkg::CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_q <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_q;
    assign o_busy  = r_clr_busy;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for cell_pattern_intern_table_core
// Drives command beats with random idle gaps and output back-pressure, keeps a
// cycle-free model of the dictionary and grid, and checks every result beat in
// order.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // read codes have no names in the package; 6 and 7 behave as read
    localparam logic [2:0] CMD_READ   = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam int DRAIN_CYCLES = 4 * (cpit_pkg::TABLE_ENTRIES + 8) + 64;
    localparam int PHASE_A_BEATS = 380;
    localparam int PHASE_C_BEATS = 180;

    typedef logic [3:0][7:0] t_pattern;

    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] x;
        logic [6:0] z;
        logic [1:0] dir;
        t_pattern   pat;
    } t_grid_cmd;

    typedef struct packed {
        logic [cpit_pkg::IDX_W-1:0] entry_index;
        logic [cpit_pkg::CNT_W-1:0] entry_total;
        logic                       table_full;
        logic [7:0]                 caps_b0;
        logic [7:0]                 caps_b1;
        logic [7:0]                 caps_b2;
        logic [7:0]                 caps_b3;
    } t_cell_result;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_cmd        = '0;
    logic [6:0]  i_cell_x     = '0;
    logic [6:0]  i_cell_z     = '0;
    logic [1:0]  i_direction  = '0;
    logic [7:0]  i_pattern_b0 = '0;
    logic [7:0]  i_pattern_b1 = '0;
    logic [7:0]  i_pattern_b2 = '0;
    logic [7:0]  i_pattern_b3 = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [9:0]  o_entry_index;
    logic [10:0] o_entry_total;
    logic        o_table_full;
    logic [7:0]  o_caps_b0;
    logic [7:0]  o_caps_b1;
    logic [7:0]  o_caps_b2;
    logic [7:0]  o_caps_b3;

    cell_pattern_intern_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_cell_x      (i_cell_x),
        .i_cell_z      (i_cell_z),
        .i_direction   (i_direction),
        .i_pattern_b0  (i_pattern_b0),
        .i_pattern_b1  (i_pattern_b1),
        .i_pattern_b2  (i_pattern_b2),
        .i_pattern_b3  (i_pattern_b3),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_entry_index (o_entry_index),
        .o_entry_total (o_entry_total),
        .o_table_full  (o_table_full),
        .o_caps_b0     (o_caps_b0),
        .o_caps_b1     (o_caps_b1),
        .o_caps_b2     (o_caps_b2),
        .o_caps_b3     (o_caps_b3)
    );

    // model state
    t_pattern                   dict_mem [cpit_pkg::TABLE_ENTRIES];
    int                         dict_used;
    logic [cpit_pkg::IDX_W-1:0] grid_idx [cpit_pkg::CELLS];

    t_grid_cmd    cmd_backlog [$];
    t_cell_result due_results [$];
    t_pattern     recent_pats [$];

    int n_issued   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int fail_count = 0;
    int reported   = 0;

    logic [6:0] hot_x = '0;
    logic [6:0] hot_z = '0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #60_000_000;
        $display("cell_pattern_intern_table_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // dictionary model
    // ------------------------------------------------------------------------
    function automatic bit intern_pattern(int cell_no, t_pattern p);
        for (int i = 0; i < dict_used; i++) begin
            if (dict_mem[i] == p) begin
                grid_idx[cell_no] = cpit_pkg::IDX_W'(i);
                return 1'b0;
            end
        end
        if (dict_used >= cpit_pkg::TABLE_ENTRIES) return 1'b1;
        dict_mem[dict_used] = p;
        grid_idx[cell_no]   = cpit_pkg::IDX_W'(dict_used);
        dict_used++;
        return 1'b0;
    endfunction

    function automatic t_cell_result apply_grid_command(t_grid_cmd c);
        t_cell_result r;
        t_pattern     p;
        int           cell_no;
        int           ncell;
        int           nx;
        int           nz;
        bit           refused;
        refused = 1'b0;
        cell_no = int'(c.z) * cpit_pkg::MAP_SIDE + int'(c.x);
        case (c.cmd)
            cpit_pkg::CMD_STORE: begin
                refused = intern_pattern(cell_no, c.pat);
            end
            cpit_pkg::CMD_CLR_GO: begin
                p        = dict_mem[grid_idx[cell_no]];
                p[c.dir] = p[c.dir] & ~cpit_pkg::GO_BIT;
                refused  = intern_pattern(cell_no, p);
            end
            cpit_pkg::CMD_SET_GO: begin
                p        = dict_mem[grid_idx[cell_no]];
                p[c.dir] = cpit_pkg::GO_BIT;
                refused  = intern_pattern(cell_no, p);
            end
            cpit_pkg::CMD_BLK_BITS, cpit_pkg::CMD_BLK_WHOLE: begin
                // neighbour i gets its byte i cut: +x, -x, +z, -z
                for (int i = 0; i < 4; i++) begin
                    nx = int'(c.x);
                    nz = int'(c.z);
                    case (i)
                        0:       nx = nx + 1;
                        1:       nx = nx - 1;
                        2:       nz = nz + 1;
                        default: nz = nz - 1;
                    endcase
                    if (nx >= 0 && nx < cpit_pkg::MAP_SIDE &&
                        nz >= 0 && nz < cpit_pkg::MAP_SIDE) begin
                        ncell = nz * cpit_pkg::MAP_SIDE + nx;
                        p     = dict_mem[grid_idx[ncell]];
                        p[i]  = (c.cmd == cpit_pkg::CMD_BLK_BITS) ?
                                (p[i] & ~cpit_pkg::GO_BIT) : 8'h00;
                        if (intern_pattern(ncell, p)) refused = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        p = dict_mem[grid_idx[cell_no]];
        r.entry_index = (c.cmd == cpit_pkg::CMD_BLK_BITS ||
                         c.cmd == cpit_pkg::CMD_BLK_WHOLE) ? '0 : grid_idx[cell_no];
        r.entry_total = cpit_pkg::CNT_W'(dict_used);
        r.table_full  = refused;
        r.caps_b0     = p[0];
        r.caps_b1     = p[1];
        r.caps_b2     = p[2];
        r.caps_b3     = p[3];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_grid_cmd mk_beat(logic [2:0] cmd, logic [6:0] x, logic [6:0] z,
                                          logic [1:0] dir, t_pattern pat);
        t_grid_cmd b;
        b.cmd = cmd;
        b.x   = x;
        b.z   = z;
        b.dir = dir;
        b.pat = pat;
        return b;
    endfunction

    task automatic queue_beat(t_grid_cmd b);
        cmd_backlog.push_back(b);
        n_issued++;
    endtask

    task automatic move_hot_spot();
        case ($urandom_range(0, 2))
            0:       hot_x = 7'd0;
            1:       hot_x = 7'd122;
            default: hot_x = 7'($urandom_range(0, 122));
        endcase
        case ($urandom_range(0, 2))
            0:       hot_z = 7'd0;
            1:       hot_z = 7'd122;
            default: hot_z = 7'($urandom_range(0, 122));
        endcase
    endtask

    // a small cluster keeps block commands landing on cells with history
    task automatic pick_cell(output logic [6:0] x, output logic [6:0] z);
        int r;
        r = $urandom_range(0, 99);
        x = 7'($urandom_range(0, 127));
        z = 7'($urandom_range(0, 127));
        if (r < 45) begin
            x = hot_x + 7'($urandom_range(0, 5));
            z = hot_z + 7'($urandom_range(0, 5));
        end else if (r < 55) begin
            x = $urandom_range(0, 1) ? 7'd127 : 7'd0;
        end else if (r < 65) begin
            z = $urandom_range(0, 1) ? 7'd127 : 7'd0;
        end
    endtask

    function automatic t_pattern pick_pattern(int fresh_pct);
        t_pattern p;
        int       r;
        r = $urandom_range(0, 99);
        p = $urandom;
        if (r >= fresh_pct) begin
            if (r < fresh_pct + 20 && recent_pats.size() > 0) begin
                p = recent_pats[$urandom_range(0, recent_pats.size() - 1)];
            end else begin
                for (int k = 0; k < 4; k++) begin
                    case ($urandom_range(0, 4))
                        0:       p[k] = 8'h00;
                        1:       p[k] = cpit_pkg::GO_BIT;
                        2:       p[k] = 8'hFE;
                        3:       p[k] = 8'hFF;
                        default: p[k] = 8'($urandom_range(0, 255));
                    endcase
                end
            end
        end
        return p;
    endfunction

    task automatic make_random_beat(int fresh_pct);
        logic [2:0] cmd;
        logic [6:0] x;
        logic [6:0] z;
        t_pattern   p;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 30)      cmd = cpit_pkg::CMD_STORE;
        else if (r < 43) cmd = cpit_pkg::CMD_CLR_GO;
        else if (r < 56) cmd = cpit_pkg::CMD_SET_GO;
        else if (r < 68) cmd = cpit_pkg::CMD_BLK_BITS;
        else if (r < 78) cmd = cpit_pkg::CMD_BLK_WHOLE;
        else if (r < 92) cmd = CMD_READ;
        else if (r < 96) cmd = CMD_SPARE6;
        else             cmd = CMD_SPARE7;
        pick_cell(x, z);
        p = (cmd == cpit_pkg::CMD_STORE) ? pick_pattern(fresh_pct) : t_pattern'($urandom);
        if (cmd == cpit_pkg::CMD_STORE) begin
            recent_pats.push_back(p);
            if (recent_pats.size() > 64) void'(recent_pats.pop_front());
        end
        queue_beat(mk_beat(cmd, x, z, 2'($urandom_range(0, 3)), p));
    endtask

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < cpit_pkg::CELLS; i++) grid_idx[i] = '0;
        for (int i = 0; i < cpit_pkg::TABLE_ENTRIES; i++) dict_mem[i] = '0;
        for (int i = 0; i < cpit_pkg::PRESETS; i++) begin
            for (int k = 0; k < 4; k++) dict_mem[i][k] = i[k] ? 8'h00 : cpit_pkg::GO_BIT;
        end
        dict_used = cpit_pkg::PRESETS;

        // directed: presets, corners, byte extremes, every command
        queue_beat(mk_beat(CMD_READ,                7'd0,   7'd0,   2'd0, 32'h0000_0000));
        queue_beat(mk_beat(cpit_pkg::CMD_STORE,     7'd127, 7'd127, 2'd3, 32'h0100_0100));
        queue_beat(mk_beat(cpit_pkg::CMD_STORE,     7'd0,   7'd127, 2'd0, 32'hFFFF_FFFF));
        queue_beat(mk_beat(cpit_pkg::CMD_STORE,     7'd127, 7'd0,   2'd1, 32'h0000_0000));
        queue_beat(mk_beat(cpit_pkg::CMD_STORE,     7'd5,   7'd5,   2'd2, 32'hFFFF_FFFF));
        queue_beat(mk_beat(cpit_pkg::CMD_CLR_GO,    7'd5,   7'd5,   2'd0, 32'hFFFF_FFFF));
        queue_beat(mk_beat(cpit_pkg::CMD_CLR_GO,    7'd5,   7'd5,   2'd3, 32'h0000_0000));
        queue_beat(mk_beat(cpit_pkg::CMD_SET_GO,    7'd5,   7'd5,   2'd1, 32'h0000_0000));
        queue_beat(mk_beat(cpit_pkg::CMD_SET_GO,    7'd5,   7'd5,   2'd2, 32'hFFFF_FFFF));
        queue_beat(mk_beat(cpit_pkg::CMD_CLR_GO,    7'd0,   7'd0,   2'd1, 32'h0000_0000));
        queue_beat(mk_beat(cpit_pkg::CMD_CLR_GO,    7'd127, 7'd0,   2'd2, 32'h0000_0000));
        queue_beat(mk_beat(cpit_pkg::CMD_BLK_BITS,  7'd0,   7'd0,   2'd0, 32'h0000_0000));
        queue_beat(mk_beat(cpit_pkg::CMD_BLK_BITS,  7'd127, 7'd127, 2'd3, 32'hFFFF_FFFF));
        queue_beat(mk_beat(cpit_pkg::CMD_BLK_WHOLE, 7'd0,   7'd127, 2'd1, 32'h0000_0000));
        queue_beat(mk_beat(cpit_pkg::CMD_BLK_WHOLE, 7'd127, 7'd0,   2'd2, 32'hFFFF_FFFF));
        queue_beat(mk_beat(cpit_pkg::CMD_BLK_BITS,  7'd6,   7'd5,   2'd0, 32'h0000_0000));
        queue_beat(mk_beat(cpit_pkg::CMD_BLK_WHOLE, 7'd5,   7'd6,   2'd3, 32'h0000_0000));
        queue_beat(mk_beat(CMD_SPARE6,              7'd5,   7'd5,   2'd0, 32'hFFFF_FFFF));
        queue_beat(mk_beat(CMD_SPARE7,              7'd127, 7'd127, 2'd3, 32'h0000_0000));
        queue_beat(mk_beat(cpit_pkg::CMD_STORE,     7'd64,  7'd64,  2'd1, 32'h807F_0180));
        queue_beat(mk_beat(CMD_READ,                7'd64,  7'd64,  2'd2, 32'hFFFF_FFFF));
        queue_beat(mk_beat(cpit_pkg::CMD_SET_GO,    7'd0,   7'd127, 2'd0, 32'h0000_0000));

        // random, mostly reused patterns
        for (int n = 0; n < PHASE_A_BEATS; n++) begin
            if (n % 48 == 0) move_hot_spot();
            make_random_beat(30);
        end

        // random, mostly fresh patterns
        for (int n = 0; n < PHASE_C_BEATS; n++) begin
            if (n % 48 == 0) move_hot_spot();
            make_random_beat(60);
        end

        wait (n_accepted == n_issued);
        wait (n_checked >= n_accepted);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && due_results.size() == 0) begin
            $display("cell_pattern_intern_table_core: match");
        end else begin
            $display("cell_pattern_intern_table_core: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // command driver
    // ------------------------------------------------------------------------
    t_grid_cmd beat_now;
    int        idle_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            idle_left  <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                due_results.push_back(apply_grid_command(beat_now));
                n_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (idle_left > 0) begin
                    i_in_valid <= 1'b0;
                    idle_left  <= idle_left - 1;
                end else if (cmd_backlog.size() > 0) begin
                    beat_now = cmd_backlog.pop_front();
                    i_cmd        <= beat_now.cmd;
                    i_cell_x     <= beat_now.x;
                    i_cell_z     <= beat_now.z;
                    i_direction  <= beat_now.dir;
                    i_pattern_b0 <= beat_now.pat[0];
                    i_pattern_b1 <= beat_now.pat[1];
                    i_pattern_b2 <= beat_now.pat[2];
                    i_pattern_b3 <= beat_now.pat[3];
                    i_in_valid   <= 1'b1;
                    idle_left    <= pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and output back-pressure
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_cell_result want;
        bit           bad;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (reported < 10) begin
                        reported++;
                        $display("unexpected result beat: index %0d total %0d full %0d",
                                 o_entry_index, o_entry_total, o_table_full);
                    end
                end else begin
                    want = due_results.pop_front();
                    n_checked++;
                    bad = (o_entry_index !== want.entry_index) ||
                          (o_entry_total !== want.entry_total) ||
                          (o_table_full  !== want.table_full)  ||
                          (o_caps_b0     !== want.caps_b0)     ||
                          (o_caps_b1     !== want.caps_b1)     ||
                          (o_caps_b2     !== want.caps_b2)     ||
                          (o_caps_b3     !== want.caps_b3);
                    if (bad) begin
                        fail_count++;
                        if (reported < 10) begin
                            reported++;
                            $display("result %0d: exp idx %0d tot %0d full %0d caps %h_%h_%h_%h",
                                     n_checked, want.entry_index, want.entry_total,
                                     want.table_full, want.caps_b3, want.caps_b2,
                                     want.caps_b1, want.caps_b0);
                            $display("result %0d: got idx %0d tot %0d full %0d caps %h_%h_%h_%h",
                                     n_checked, o_entry_index, o_entry_total, o_table_full,
                                     o_caps_b3, o_caps_b2, o_caps_b1, o_caps_b0);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end else begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                stall_left  <= pick_gap();
            end
        end
    end

endmodule

// File: files.f
src/cpit_pkg.sv
src/cpit_dict.sv
src/cpit_grid.sv
src/cell_pattern_intern_table_core.sv
dv/tb_top.sv
